[hdl/servo_write_packet_engine_assert.svh]
// assertion macros for the servo write packet engine
// used by the top level; no other dependencies
`ifndef SERVO_WRITE_PACKET_ENGINE_ASSERT_SVH
`define SERVO_WRITE_PACKET_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SWPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swpe assertion failed");

// next-cycle implication, checked out of reset
`define SWPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swpe assertion failed");

`else

`define SWPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SWPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/swpe_pkg.sv]
// shared types and constants of the servo write packet engine
// no dependencies
package swpe_pkg;

	// request action codes
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_REPLY = 2'd2;

	// protocol bytes
	localparam logic [7:0] SYNC_BYTE      = 8'hFF;
	localparam logic [7:0] OPC_WRITE      = 8'h03;
	localparam logic [7:0] LEN_EXTRA      = 8'd3;
	localparam logic [7:0] REPLY_LEN_BYTE = 8'd2;
	localparam logic [7:0] REPLY_NO_ERR   = 8'd0;

	// positions inside a status reply
	localparam logic [2:0] RPOS_SYNC1 = 3'd1;
	localparam logic [2:0] RPOS_SYNC2 = 3'd2;
	localparam logic [2:0] RPOS_ID    = 3'd3;
	localparam logic [2:0] RPOS_LEN   = 3'd4;
	localparam logic [2:0] RPOS_ERR   = 3'd5;
	localparam logic [2:0] RPOS_CHK   = 3'd6;

	// positions inside a header burst
	localparam logic [2:0] HPOS_SYNC1 = 3'd0;
	localparam logic [2:0] HPOS_SYNC2 = 3'd1;
	localparam logic [2:0] HPOS_ID    = 3'd2;
	localparam logic [2:0] HPOS_LEN   = 3'd3;
	localparam logic [2:0] HPOS_OPC   = 3'd4;
	localparam logic [2:0] HPOS_ADDR  = 3'd5;
	localparam logic [2:0] HPOS_CHK   = 3'd6;

	// burst lengths
	localparam logic [2:0] HDR_CNT      = 3'd6;
	localparam logic [2:0] HDR_CHK_CNT  = 3'd7;
	localparam logic [2:0] DATA_CNT     = 3'd1;
	localparam logic [2:0] DATA_CHK_CNT = 3'd2;
	localparam logic [2:0] VERDICT_CNT  = 3'd1;
	localparam logic [2:0] DPOS_CHK     = 3'd1;

	typedef enum logic [1:0] {
		KIND_HDR,
		KIND_DATA,
		KIND_VERDICT
	} kind_t;

	// one accepted request, expanded into a burst of responses
	typedef struct packed {
		kind_t      kind;
		logic [2:0] cnt;
		logic [7:0] id;
		logic [7:0] lenb;
		logic [7:0] addr;
		logic [7:0] data;
		logic [7:0] chk;
		logic       ok;
	} burst_t;

endpackage

[hdl/swpe_cmd_if.sv]
// request channel of the servo write packet engine
// no dependencies
interface swpe_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] servo_id;
	logic [7:0] reg_address;
	logic [7:0] payload_length;
	logic [7:0] data_byte;

	modport source (
		output valid, action, servo_id, reg_address, payload_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, action, servo_id, reg_address, payload_length, data_byte,
		output ready
	);
endinterface

[hdl/swpe_rsp_if.sv]
// response channel of the servo write packet engine
// no dependencies
interface swpe_rsp_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic       reply_done;
	logic       reply_ok;

	modport source (
		output valid, tx_valid, tx_byte, tx_last, reply_done, reply_ok,
		input  ready
	);
	modport sink (
		input  valid, tx_valid, tx_byte, tx_last, reply_done, reply_ok,
		output ready
	);
endinterface

[hdl/servo_write_packet_engine.sv]
// servo write packet engine: frames write instruction packets and checks status replies
// depends on swpe_pkg, swpe_cmd_if, swpe_rsp_if and servo_write_packet_engine_assert.svh
//
// usage:
// - cmd carries one request per handshake: a start (id, address, payload length),
//   a payload data byte, or one received reply byte
// - rsp carries the resulting bytes to transmit and reply verdicts, one per handshake
// - a start gives six header bytes, plus the checksum when the length is zero;
//   a data byte gives itself, plus the checksum when it is the last one;
//   the seventh reply byte gives one verdict; everything else gives nothing
// - the first response of a request passes through the burst stage, then the output
//   register, before it appears on rsp
// - throughput: one response per cycle while rsp does not stall; a request holds the
//   burst stage until its last response leaves, a request with none is taken on cmd
//   without filling it, and cmd.ready comes back in the cycle the last response of the
//   burst moves to the output register
// - when rsp stalls the output register and burst stage hold, and cmd.ready drops
//   once the burst stage cannot drain
// - reset clears all packet and reply state, and both stages come up empty
`include "servo_write_packet_engine_assert.svh"

module servo_write_packet_engine (
	input logic        clk,
	input logic        arst_n,
	swpe_cmd_if.sink   cmd,
	swpe_rsp_if.source rsp
);

	// packet and reply tracking state
	logic [7:0] tid_q, tid_d;
	logic [7:0] rem_q, rem_d;
	logic [7:0] tsum_q, tsum_d;
	logic [2:0] rpos_q, rpos_d;
	logic [7:0] rsum_q, rsum_d;
	logic       good_q, good_d;

	// expansion of the request being accepted
	swpe_pkg::burst_t ent;
	logic             ent_has;

	// burst stage
	logic             s1_valid_q;
	swpe_pkg::burst_t st_s1;
	logic [2:0]       idx_s1;

	// output register
	logic       rsp_valid_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;
	logic       tx_last_q;
	logic       done_q;
	logic       ok_q;

	logic       accept;
	logic       load_out;
	logic       emit;
	logic       fin;
	logic       chk_ok;
	logic [7:0] lenb;
	logic [7:0] dsum;
	logic [7:0] rem_dec;

	logic       e_tx_valid;
	logic [7:0] e_tx_byte;
	logic       e_tx_last;

	assign load_out  = !rsp_valid_q || rsp.ready;
	assign emit      = s1_valid_q && load_out;
	assign fin       = emit && (idx_s1 == st_s1.cnt - 3'd1);
	assign cmd.ready = !s1_valid_q || fin;
	assign accept    = cmd.valid && cmd.ready;

	assign lenb    = cmd.payload_length + swpe_pkg::LEN_EXTRA;
	assign dsum    = tsum_q + cmd.data_byte;
	assign rem_dec = rem_q - 8'd1;

	// reply byte check against its position
	always_comb begin
		chk_ok = 1'b1;
		case (rpos_q)
			swpe_pkg::RPOS_SYNC1: chk_ok = (cmd.data_byte == swpe_pkg::SYNC_BYTE);
			swpe_pkg::RPOS_SYNC2: chk_ok = (cmd.data_byte == swpe_pkg::SYNC_BYTE);
			swpe_pkg::RPOS_ID:    chk_ok = (cmd.data_byte == tid_q);
			swpe_pkg::RPOS_LEN:   chk_ok = (cmd.data_byte == swpe_pkg::REPLY_LEN_BYTE);
			swpe_pkg::RPOS_ERR:   chk_ok = (cmd.data_byte == swpe_pkg::REPLY_NO_ERR);
			swpe_pkg::RPOS_CHK:   chk_ok = (cmd.data_byte == ~rsum_q);
			default:              chk_ok = 1'b1;
		endcase
	end

	// next state and burst description of the incoming request
	always_comb begin
		tid_d   = tid_q;
		rem_d   = rem_q;
		tsum_d  = tsum_q;
		rpos_d  = rpos_q;
		rsum_d  = rsum_q;
		good_d  = good_q;
		ent_has = 1'b0;
		ent     = '{kind: swpe_pkg::KIND_HDR, cnt: 3'd0, id: cmd.servo_id, lenb: lenb,
			addr: cmd.reg_address, data: cmd.data_byte, chk: 8'd0, ok: 1'b0};
		case (cmd.action)
			swpe_pkg::ACT_START: begin
				// new packet; any partial reply is dropped
				tid_d    = cmd.servo_id;
				rem_d    = cmd.payload_length;
				tsum_d   = cmd.servo_id + lenb + swpe_pkg::OPC_WRITE + cmd.reg_address;
				rpos_d   = 3'd0;
				rsum_d   = 8'd0;
				good_d   = 1'b1;
				ent_has  = 1'b1;
				ent.kind = swpe_pkg::KIND_HDR;
				ent.chk  = ~tsum_d;
				ent.cnt  = (cmd.payload_length == 8'd0) ? swpe_pkg::HDR_CHK_CNT
					: swpe_pkg::HDR_CNT;
			end
			swpe_pkg::ACT_DATA: begin
				if (rem_q != 8'd0) begin
					tsum_d   = dsum;
					rem_d    = rem_dec;
					ent_has  = 1'b1;
					ent.kind = swpe_pkg::KIND_DATA;
					ent.chk  = ~dsum;
					ent.cnt  = (rem_dec == 8'd0) ? swpe_pkg::DATA_CHK_CNT : swpe_pkg::DATA_CNT;
				end
			end
			swpe_pkg::ACT_REPLY: begin
				if (rpos_q == swpe_pkg::RPOS_ID || rpos_q == swpe_pkg::RPOS_LEN
					|| rpos_q == swpe_pkg::RPOS_ERR) begin
					rsum_d = rsum_q + cmd.data_byte;
				end
				if (rpos_q == swpe_pkg::RPOS_CHK) begin
					ent_has  = 1'b1;
					ent.kind = swpe_pkg::KIND_VERDICT;
					ent.cnt  = swpe_pkg::VERDICT_CNT;
					ent.ok   = good_q && chk_ok;
					rpos_d   = 3'd0;
					rsum_d   = 8'd0;
					good_d   = 1'b1;
				end else begin
					rpos_d = rpos_q + 3'd1;
					good_d = good_q && chk_ok;
				end
			end
			default: begin
			end
		endcase
	end

	// tracking state, updated on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_q  <= 8'd0;
			rem_q  <= 8'd0;
			tsum_q <= 8'd0;
			rpos_q <= 3'd0;
			rsum_q <= 8'd0;
			good_q <= 1'b1;
		end else if (accept) begin
			tid_q  <= tid_d;
			rem_q  <= rem_d;
			tsum_q <= tsum_d;
			rpos_q <= rpos_d;
			rsum_q <= rsum_d;
			good_q <= good_d;
		end
	end

	// burst stage control: occupied until its last response leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			idx_s1     <= 3'd0;
		end else if (accept) begin
			s1_valid_q <= ent_has;
			idx_s1     <= 3'd0;
		end else if (fin) begin
			s1_valid_q <= 1'b0;
		end else if (emit) begin
			idx_s1 <= idx_s1 + 3'd1;
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (accept && ent_has) begin
			st_s1 <= ent;
		end
	end

	// pick the response at the current burst position
	always_comb begin
		e_tx_valid = 1'b1;
		e_tx_byte  = 8'd0;
		e_tx_last  = 1'b0;
		case (st_s1.kind)
			swpe_pkg::KIND_HDR: begin
				case (idx_s1)
					swpe_pkg::HPOS_SYNC1: e_tx_byte = swpe_pkg::SYNC_BYTE;
					swpe_pkg::HPOS_SYNC2: e_tx_byte = swpe_pkg::SYNC_BYTE;
					swpe_pkg::HPOS_ID:    e_tx_byte = st_s1.id;
					swpe_pkg::HPOS_LEN:   e_tx_byte = st_s1.lenb;
					swpe_pkg::HPOS_OPC:   e_tx_byte = swpe_pkg::OPC_WRITE;
					swpe_pkg::HPOS_ADDR:  e_tx_byte = st_s1.addr;
					swpe_pkg::HPOS_CHK: begin
						e_tx_byte = st_s1.chk;
						e_tx_last = 1'b1;
					end
					default: e_tx_byte = 8'd0;
				endcase
			end
			swpe_pkg::KIND_DATA: begin
				if (idx_s1 == swpe_pkg::DPOS_CHK) begin
					e_tx_byte = st_s1.chk;
					e_tx_last = 1'b1;
				end else begin
					e_tx_byte = st_s1.data;
				end
			end
			default: e_tx_valid = 1'b0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_valid_q <= e_tx_valid;
			tx_byte_q  <= e_tx_byte;
			tx_last_q  <= e_tx_last;
			done_q     <= !e_tx_valid;
			ok_q       <= !e_tx_valid && st_s1.ok;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.tx_valid   = tx_valid_q;
	assign rsp.tx_byte    = tx_byte_q;
	assign rsp.tx_last    = tx_last_q;
	assign rsp.reply_done = done_q;
	assign rsp.reply_ok   = ok_q;

	`SWPE_ASSERT_IMP(a_idx_in_burst, clk, arst_n, s1_valid_q, idx_s1 < st_s1.cnt)
	`SWPE_ASSERT_IMP(a_rpos_range, clk, arst_n, 1'b1, rpos_q <= swpe_pkg::RPOS_CHK)
	`SWPE_ASSERT_IMP(a_last_is_tx, clk, arst_n, rsp.valid && rsp.tx_last, rsp.tx_valid && !rsp.reply_done)
	`SWPE_ASSERT_IMP(a_verdict_single, clk, arst_n, s1_valid_q && st_s1.kind == swpe_pkg::KIND_VERDICT, st_s1.cnt == swpe_pkg::VERDICT_CNT)
	`SWPE_ASSERT_NXT(a_stall_holds_burst, clk, arst_n, s1_valid_q && !load_out, s1_valid_q && $stable(idx_s1))

endmodule
